>>> rtl/gclb_pkg.sv
// ----------------------------------------------------------------------------
// gclb_pkg
// Shared constants, command and status types for the gcd/lcm/Bezout unit.
// ----------------------------------------------------------------------------
package gclb_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAG_W     = 31;
  localparam int DIV_W     = 64;
  localparam int NARROW_W  = 32;
  localparam int CNT_W     = 7;

  typedef logic [4:0] op_t;
  localparam op_t OP_NOP      = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_DIV_EU   = 5'd2;
  localparam op_t OP_EU_Q     = 5'd3;
  localparam op_t OP_UPD1     = 5'd4;
  localparam op_t OP_UPD2     = 5'd5;
  localparam op_t OP_DIV_QB   = 5'd6;
  localparam op_t OP_SET_QB   = 5'd7;
  localparam op_t OP_DIV_QA   = 5'd8;
  localparam op_t OP_SET_QA   = 5'd9;
  localparam op_t OP_LCM      = 5'd10;
  localparam op_t OP_NUM      = 5'd11;
  localparam op_t OP_NUMSUB   = 5'd12;
  localparam op_t OP_DEN      = 5'd13;
  localparam op_t OP_DENADD   = 5'd14;
  localparam op_t OP_DIV_N    = 5'd15;
  localparam op_t OP_SET_N    = 5'd16;
  localparam op_t OP_XA       = 5'd17;
  localparam op_t OP_XB       = 5'd18;
  localparam op_t OP_FIN      = 5'd19;
  localparam op_t OP_FIN_ZERO = 5'd20;

  typedef logic [3:0] msel_t;
  localparam msel_t MS_QW1  = 4'd0;
  localparam msel_t MS_QW2  = 4'd1;
  localparam msel_t MS_QBMB = 4'd2;
  localparam msel_t MS_U2QB = 4'd3;
  localparam msel_t MS_U1QA = 4'd4;
  localparam msel_t MS_QAQA = 4'd5;
  localparam msel_t MS_QBQB = 4'd6;
  localparam msel_t MS_NQA  = 4'd7;
  localparam msel_t MS_NQB  = 4'd8;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic pb_zero;
    logic div_done;
  } stat_t;

  function automatic logic [31:0] sat_fix(input logic signed [63:0] x, input logic neg);
    logic signed [63:0] lim;
    logic signed [63:0] s;
    logic [31:0] r;
    lim = 64'sd2147483647;
    if (x > lim) begin
      s = lim;
    end else if (x < -lim) begin
      s = -lim;
    end else begin
      s = x;
    end
    r = s[31:0];
    return neg ? (32'd0 - r) : r;
  endfunction

endpackage

>>> rtl/gclb_div.sv
// ----------------------------------------------------------------------------
// gclb_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle,
// 32 or 64 steps.
// ----------------------------------------------------------------------------
module gclb_div import gclb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             wide_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o,
  output logic [DIV_W-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = divisor_i;
      if (wide_i) begin
        quo_d = dividend_i;
        cnt_d = CNT_W'(DIV_W);
      end else begin
        quo_d = {dividend_i[NARROW_W-1:0], {(DIV_W-NARROW_W){1'b0}}};
        cnt_d = CNT_W'(NARROW_W);
      end
    end else if (busy_q) begin
      rem_d = ge ? DIV_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/gclb_dp.sv
// ----------------------------------------------------------------------------
// gclb_dp
// Datapath: operand decode, Euclid registers, shared multiplier, divider
// and the result register.
// ----------------------------------------------------------------------------
module gclb_dp import gclb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  output logic [30:0]        gcd_out_o,
  output logic [61:0]        lcm_out_o,
  output logic signed [31:0] coef_a_o,
  output logic signed [31:0] coef_b_o,
  output logic               bezout_valid_o
);

  logic [WORD_BITS-1:0] raw_a, raw_b, mag_a, mag_b;
  logic [MAG_W-1:0]     dec_a, dec_b;

  logic [MAG_W-1:0] ma_q, mb_q, pa_q, pb_q, q_q, r_q, qa_q, qb_q;
  logic             na_q, nb_q;
  logic [32:0]      u1_q, u2_q, w1_q, w2_q, n_q;
  logic [61:0]      lcm_q;
  logic [63:0]      num_q, den_q, prod_q, xa_q, xb_q;

  logic [30:0]        gcd_o_q;
  logic [61:0]        lcm_o_q;
  logic [31:0]        ca_o_q, cb_o_q;
  logic               bv_o_q;

  logic signed [33:0] opa, opb;
  logic signed [67:0] mul_full;

  logic             div_start, div_wide, div_done;
  logic [DIV_W-1:0] div_dnd, div_dvs, div_quo, div_rem;

  always_comb begin
    raw_a = value_a_i[WORD_BITS-1:0];
    raw_b = value_b_i[WORD_BITS-1:0];
    mag_a = raw_a[WORD_BITS-1] ? (WORD_BITS'(0) - raw_a) : raw_a;
    mag_b = raw_b[WORD_BITS-1] ? (WORD_BITS'(0) - raw_b) : raw_b;
    dec_a = mag_a[WORD_BITS-1] ? MAG_W'({(WORD_BITS-1){1'b1}}) : MAG_W'(mag_a[WORD_BITS-2:0]);
    dec_b = mag_b[WORD_BITS-1] ? MAG_W'({(WORD_BITS-1){1'b1}}) : MAG_W'(mag_b[WORD_BITS-2:0]);
  end

  always_comb begin
    case (cmd_i.msel)
      MS_QW1:  begin opa = $signed({3'b000, q_q});  opb = $signed({w1_q[32], w1_q}); end
      MS_QW2:  begin opa = $signed({3'b000, q_q});  opb = $signed({w2_q[32], w2_q}); end
      MS_QBMB: begin opa = $signed({3'b000, qb_q}); opb = $signed({3'b000, mb_q}); end
      MS_U2QB: begin opa = $signed({u2_q[32], u2_q}); opb = $signed({3'b000, qb_q}); end
      MS_U1QA: begin opa = $signed({u1_q[32], u1_q}); opb = $signed({3'b000, qa_q}); end
      MS_QAQA: begin opa = $signed({3'b000, qa_q}); opb = $signed({3'b000, qa_q}); end
      MS_QBQB: begin opa = $signed({3'b000, qb_q}); opb = $signed({3'b000, qb_q}); end
      MS_NQA:  begin opa = $signed({n_q[32], n_q});  opb = $signed({3'b000, qa_q}); end
      MS_NQB:  begin opa = $signed({n_q[32], n_q});  opb = $signed({3'b000, qb_q}); end
      default: begin opa = '0; opb = '0; end
    endcase
    mul_full = opa * opb;
  end

  always_comb begin
    div_start = 1'b0;
    div_wide  = 1'b0;
    div_dnd   = {33'd0, pa_q};
    div_dvs   = {33'd0, pb_q};
    case (cmd_i.op)
      OP_DIV_EU: div_start = 1'b1;
      OP_DIV_QB: begin
        div_start = 1'b1;
        div_dnd   = {33'd0, ma_q};
        div_dvs   = {33'd0, pa_q};
      end
      OP_DIV_QA: begin
        div_start = 1'b1;
        div_dnd   = {33'd0, mb_q};
        div_dvs   = {33'd0, pa_q};
      end
      OP_DIV_N: begin
        div_start = 1'b1;
        div_wide  = 1'b1;
        div_dnd   = num_q[63] ? (64'd0 - num_q) : num_q;
        div_dvs   = den_q;
      end
      default: ;
    endcase
  end

  gclb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .wide_i     (div_wide),
    .dividend_i (div_dnd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
    case (cmd_i.op)
      OP_LOAD: begin
        ma_q <= dec_a;
        mb_q <= dec_b;
        pa_q <= dec_a;
        pb_q <= dec_b;
        na_q <= raw_a[WORD_BITS-1];
        nb_q <= raw_b[WORD_BITS-1];
        u1_q <= 33'd1;
        u2_q <= 33'd0;
        w1_q <= 33'd0;
        w2_q <= 33'd1;
      end
      OP_EU_Q: begin
        q_q <= div_quo[MAG_W-1:0];
        r_q <= div_rem[MAG_W-1:0];
      end
      OP_UPD1: begin
        u1_q <= w1_q;
        w1_q <= u1_q - prod_q[32:0];
      end
      OP_UPD2: begin
        u2_q <= w2_q;
        w2_q <= u2_q - prod_q[32:0];
        pa_q <= pb_q;
        pb_q <= r_q;
      end
      OP_SET_QB: qb_q <= div_quo[MAG_W-1:0];
      OP_SET_QA: qa_q <= div_quo[MAG_W-1:0];
      OP_LCM:    lcm_q <= prod_q[61:0];
      OP_NUM:    num_q <= prod_q;
      OP_NUMSUB: num_q <= num_q - prod_q;
      OP_DEN:    den_q <= prod_q;
      OP_DENADD: den_q <= den_q + prod_q;
      OP_SET_N:  n_q <= num_q[63] ? (33'd0 - div_quo[32:0]) : div_quo[32:0];
      OP_XA:     xa_q <= {{31{u1_q[32]}}, u1_q} + prod_q;
      OP_XB:     xb_q <= {{31{u2_q[32]}}, u2_q} - prod_q;
      OP_FIN: begin
        gcd_o_q <= pa_q;
        lcm_o_q <= lcm_q;
        ca_o_q  <= sat_fix($signed(xa_q), na_q);
        cb_o_q  <= sat_fix($signed(xb_q), nb_q);
        bv_o_q  <= 1'b1;
      end
      OP_FIN_ZERO: begin
        gcd_o_q <= (ma_q == '0) ? mb_q : ma_q;
        lcm_o_q <= '0;
        ca_o_q  <= '0;
        cb_o_q  <= '0;
        bv_o_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign stat_o.zero     = (ma_q == '0) || (mb_q == '0);
  assign stat_o.pb_zero  = (pb_q == '0);
  assign stat_o.div_done = div_done;

  assign gcd_out_o      = gcd_o_q;
  assign lcm_out_o      = lcm_o_q;
  assign coef_a_o       = $signed(ca_o_q);
  assign coef_b_o       = $signed(cb_o_q);
  assign bezout_valid_o = bv_o_q;

endmodule

>>> rtl/gclb_ctrl.sv
// ----------------------------------------------------------------------------
// gclb_ctrl
// Controller: sequences the Euclid loop, the quotient divisions, the
// coefficient reduction and the output handshake.
// ----------------------------------------------------------------------------
module gclb_ctrl import gclb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_LOOP   = 5'd2;
  localparam logic [4:0] S_EDIV   = 5'd3;
  localparam logic [4:0] S_EWAIT  = 5'd4;
  localparam logic [4:0] S_EQ     = 5'd5;
  localparam logic [4:0] S_MQ1    = 5'd6;
  localparam logic [4:0] S_UPD1   = 5'd7;
  localparam logic [4:0] S_UPD2   = 5'd8;
  localparam logic [4:0] S_QBDIV  = 5'd9;
  localparam logic [4:0] S_QBWAIT = 5'd10;
  localparam logic [4:0] S_QBSET  = 5'd11;
  localparam logic [4:0] S_QADIV  = 5'd12;
  localparam logic [4:0] S_QAWAIT = 5'd13;
  localparam logic [4:0] S_QASET  = 5'd14;
  localparam logic [4:0] S_M1     = 5'd15;
  localparam logic [4:0] S_M2     = 5'd16;
  localparam logic [4:0] S_M3     = 5'd17;
  localparam logic [4:0] S_M4     = 5'd18;
  localparam logic [4:0] S_M5     = 5'd19;
  localparam logic [4:0] S_M6     = 5'd20;
  localparam logic [4:0] S_NDIV   = 5'd21;
  localparam logic [4:0] S_NWAIT  = 5'd22;
  localparam logic [4:0] S_NSET   = 5'd23;
  localparam logic [4:0] S_M7     = 5'd24;
  localparam logic [4:0] S_M8     = 5'd25;
  localparam logic [4:0] S_M9     = 5'd26;
  localparam logic [4:0] S_FIN    = 5'd27;
  localparam logic [4:0] S_FINZ   = 5'd28;

  logic [4:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       out_free;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NOP;
    cmd_o.msel = MS_QW1;
    ov_d       = ov_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK:  state_d = stat_i.zero ? S_FINZ : S_LOOP;
      S_LOOP:   state_d = stat_i.pb_zero ? S_QBDIV : S_EDIV;
      S_EDIV: begin
        cmd_o.op = OP_DIV_EU;
        state_d  = S_EWAIT;
      end
      S_EWAIT:  if (stat_i.div_done) state_d = S_EQ;
      S_EQ: begin
        cmd_o.op = OP_EU_Q;
        state_d  = S_MQ1;
      end
      S_MQ1: begin
        cmd_o.msel = MS_QW1;
        state_d    = S_UPD1;
      end
      S_UPD1: begin
        cmd_o.op   = OP_UPD1;
        cmd_o.msel = MS_QW2;
        state_d    = S_UPD2;
      end
      S_UPD2: begin
        cmd_o.op = OP_UPD2;
        state_d  = S_LOOP;
      end
      S_QBDIV: begin
        cmd_o.op = OP_DIV_QB;
        state_d  = S_QBWAIT;
      end
      S_QBWAIT: if (stat_i.div_done) state_d = S_QBSET;
      S_QBSET: begin
        cmd_o.op = OP_SET_QB;
        state_d  = S_QADIV;
      end
      S_QADIV: begin
        cmd_o.op = OP_DIV_QA;
        state_d  = S_QAWAIT;
      end
      S_QAWAIT: if (stat_i.div_done) state_d = S_QASET;
      S_QASET: begin
        cmd_o.op = OP_SET_QA;
        state_d  = S_M1;
      end
      S_M1: begin
        cmd_o.msel = MS_QBMB;
        state_d    = S_M2;
      end
      S_M2: begin
        cmd_o.op   = OP_LCM;
        cmd_o.msel = MS_U2QB;
        state_d    = S_M3;
      end
      S_M3: begin
        cmd_o.op   = OP_NUM;
        cmd_o.msel = MS_U1QA;
        state_d    = S_M4;
      end
      S_M4: begin
        cmd_o.op   = OP_NUMSUB;
        cmd_o.msel = MS_QAQA;
        state_d    = S_M5;
      end
      S_M5: begin
        cmd_o.op   = OP_DEN;
        cmd_o.msel = MS_QBQB;
        state_d    = S_M6;
      end
      S_M6: begin
        cmd_o.op = OP_DENADD;
        state_d  = S_NDIV;
      end
      S_NDIV: begin
        cmd_o.op = OP_DIV_N;
        state_d  = S_NWAIT;
      end
      S_NWAIT:  if (stat_i.div_done) state_d = S_NSET;
      S_NSET: begin
        cmd_o.op = OP_SET_N;
        state_d  = S_M7;
      end
      S_M7: begin
        cmd_o.msel = MS_NQA;
        state_d    = S_M8;
      end
      S_M8: begin
        cmd_o.op   = OP_XA;
        cmd_o.msel = MS_NQB;
        state_d    = S_M9;
      end
      S_M9: begin
        cmd_o.op = OP_XB;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.op = OP_FIN;
          ov_d     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_FINZ: begin
        if (out_free) begin
          cmd_o.op = OP_FIN_ZERO;
          ov_d     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

endmodule

>>> rtl/gcd_lcm_bezout_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_bezout_unit
// One pair at a time: the next is accepted the cycle after the result is
// registered. A pair with a zero operand skips the Euclid loop and the
// reduction. The shared bit-serial divider (32 steps per Euclid quotient, 64
// for the reduction quotient) dominates the run time. Async active-low reset
// clears control.
// ----------------------------------------------------------------------------
module gcd_lcm_bezout_unit import gclb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        gcd_out_o,
  output logic [61:0]        lcm_out_o,
  output logic signed [31:0] coef_a_o,
  output logic signed [31:0] coef_b_o,
  output logic               bezout_valid_o
);

  cmd_t  cmd;
  stat_t stat;

  gclb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gclb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_a_i      (value_a_i),
    .value_b_i      (value_b_i),
    .gcd_out_o      (gcd_out_o),
    .lcm_out_o      (lcm_out_o),
    .coef_a_o       (coef_a_o),
    .coef_b_o       (coef_b_o),
    .bezout_valid_o (bezout_valid_o)
  );

endmodule

>>> tb/gcd_lcm_bezout_unit_tb.sv
// ----------------------------------------------------------------------------
// gcd_lcm_bezout_unit_tb
// Drives signed operand pairs through the valid/ready input port with random
// gaps, predicts gcd, lcm and the reduced Bezout pair for each transaction,
// and checks every result transaction field by field in order of arrival.
// ----------------------------------------------------------------------------
module gcd_lcm_bezout_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } pair_t;

  typedef struct {
    logic [30:0]        g;
    logic [61:0]        l;
    logic signed [31:0] xa;
    logic signed [31:0] xb;
    logic               v;
  } gcd_res_t;

  localparam longint MAX_CYCLES = 64'd20_000_000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] value_a_i;
  logic signed [31:0] value_b_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [30:0]        gcd_out_o;
  logic [61:0]        lcm_out_o;
  logic signed [31:0] coef_a_o;
  logic signed [31:0] coef_b_o;
  logic               bezout_valid_o;
  logic               in_ready_o_q;

  pair_t    pair_q[$];
  gcd_res_t expected_q[$];
  int       errors;
  bit       stim_done;
  bit       hold_send;
  int       send_gap;
  int       recv_gap;
  longint   cycles;

  gcd_lcm_bezout_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic longint mag_of(logic signed [31:0] x);
    longint s;
    s = x;
    if (s < -64'sd2147483647) s = -64'sd2147483647;
    return (s < 0) ? -s : s;
  endfunction

  function automatic longint clip31(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483647) return -64'sd2147483647;
    return x;
  endfunction

  function automatic gcd_res_t predict_gcd(pair_t p);
    gcd_res_t r;
    longint ma, mb, g, t, pa, pb, u1, u2, w1, w2, q, rm, t1, t2;
    longint qa, qb, num, den, n, xa, xb;
    ma = mag_of(p.a);
    mb = mag_of(p.b);
    if (ma == 0) g = mb;
    else if (mb == 0) g = ma;
    else begin
      pa = ma; pb = mb;
      while (pb != 0) begin
        t = pa % pb; pa = pb; pb = t;
      end
      g = pa;
    end
    r.g = g[30:0];
    r.l = '0; r.xa = '0; r.xb = '0;
    r.v = (ma != 0) && (mb != 0);
    if (r.v) begin
      qa = mb / g;
      qb = ma / g;
      t = qb * mb;
      r.l = t[61:0];
      pa = ma; pb = mb; u1 = 1; u2 = 0; w1 = 0; w2 = 1;
      while (pb != 0) begin
        q = pa / pb;
        rm = pa - q * pb;
        t1 = u1 - q * w1;
        t2 = u2 - q * w2;
        u1 = w1; u2 = w2; w1 = t1; w2 = t2; pa = pb; pb = rm;
      end
      num = u2 * qb - u1 * qa;
      den = qa * qa + qb * qb;
      n = num / den;
      xa = clip31(u1 + n * qa);
      xb = clip31(u2 - n * qb);
      if (p.a < 0) xa = -xa;
      if (p.b < 0) xb = -xb;
      r.xa = xa[31:0];
      r.xb = xb[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    int k;
    logic [31:0] x;
    k = $urandom_range(0, 9);
    case (k)
      0: x = $urandom_range(0, 20);
      1: x = -$urandom_range(0, 20);
      2: x = $urandom & 32'h0000_FFFF;
      3: x = $urandom_range(0, 7) * 32'd3 * 32'd7 * 32'd11 * $urandom_range(1, 999);
      4: x = {1'($urandom_range(0, 1)), 31'(31'h7FFF_FFFF - $urandom_range(0, 3))};
      default: x = $urandom;
    endcase
    return x;
  endfunction

  task automatic push_pair(logic signed [31:0] a, logic signed [31:0] b);
    pair_t p;
    p.a = a;
    p.b = b;
    pair_q.push_back(p);
  endtask

  initial begin
    longint f1, f2;
    logic signed [31:0] m;
    errors = 0;
    stim_done = 0;
    hold_send = 0;
    cycles = 0;
    push_pair(0, 0);
    push_pair(0, 17);
    push_pair(-17, 0);
    push_pair(32'sh8000_0000, 0);
    push_pair(32'sh8000_0000, 32'sh8000_0000);
    push_pair(32'sh7FFF_FFFF, 32'sh8000_0001);
    push_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFE);
    push_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
    push_pair(1, 1);
    push_pair(-1, 1);
    push_pair(1, -1);
    push_pair(-1, -1);
    push_pair(240, 46);
    push_pair(-240, 46);
    push_pair(240, -46);
    push_pair(1836311903, 1134903170);
    push_pair(-1836311903, -1134903170);
    push_pair(32'sh7FFF_FFFF, 1);
    push_pair(12, 12);
    push_pair(65536, 32'sh4000_0000);
    push_pair(32'shFFFF_FFFF, 32'sh8000_0000);
    push_pair(32'h5555_5555, 32'hAAAA_AAAA);
    for (int i = 0; i < 1950; i++) begin
      if (i == 900) begin
        wait (pair_q.size() == 0);
        hold_send = 1;
        do @(negedge clk_i); while (expected_q.size() != 0 || in_valid_i);
        hold_send = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        f1 = $urandom_range(1, 46340);
        f2 = $urandom_range(1, 46340);
        m = 32'(f1 * $urandom_range(1, 40000));
        push_pair(($urandom_range(0, 1) ? -m : m),
                  32'(f1 * ($urandom_range(1, 46340) % (2147483647 / f1) + 1) * f2 / f2));
      end else begin
        push_pair(rand_operand(), rand_operand());
      end
    end
    stim_done = 1;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_a_i  <= '0;
      value_b_i  <= '0;
      send_gap   <= 0;
    end else if (!in_valid_i || in_ready_o_q) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pair_q.size() > 0 && !hold_send) begin
        in_valid_i <= 1'b1;
        value_a_i  <= pair_q[0].a;
        value_b_i  <= pair_q[0].b;
        void'(pair_q.pop_front());
        send_gap   <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // acceptance seen at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ready_o_q <= 1'b0;
    end else begin
      in_ready_o_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        pair_t p;
        p.a = value_a_i;
        p.b = value_b_i;
        expected_q.push_back(predict_gcd(p));
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
    end else if (recv_gap > 0) begin
      out_ready_i <= 1'b0;
      recv_gap    <= recv_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      recv_gap    <= ($urandom_range(0, 7) == 0) ? gap_len() : 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction", $realtime);
        errors++;
      end else begin
        gcd_res_t e;
        e = expected_q.pop_front();
        if (gcd_out_o !== e.g) begin
          $display("%0t: gcd_out exp %0d got %0d", $realtime, e.g, gcd_out_o);
          errors++;
        end
        if (lcm_out_o !== e.l) begin
          $display("%0t: lcm_out exp %0d got %0d", $realtime, e.l, lcm_out_o);
          errors++;
        end
        if (coef_a_o !== e.xa) begin
          $display("%0t: coef_a exp %0d got %0d", $realtime, e.xa, coef_a_o);
          errors++;
        end
        if (coef_b_o !== e.xb) begin
          $display("%0t: coef_b exp %0d got %0d", $realtime, e.xb, coef_b_o);
          errors++;
        end
        if (bezout_valid_o !== e.v) begin
          $display("%0t: bezout_valid exp %0b got %0b", $realtime, e.v, bezout_valid_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stim_done && pair_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gclb_pkg.sv
rtl/gclb_div.sv
rtl/gclb_dp.sv
rtl/gclb_ctrl.sv
rtl/gcd_lcm_bezout_unit.sv
tb/gcd_lcm_bezout_unit_tb.sv
